// ----- hw/rtl/meba_pkg.sv -----
// Shared types and constants for the microphone energy balance azimuth block.
package meba_pkg;
	localparam int EW = 41;           // energy sum width
	localparam int QW = 18;           // signed Q1.17 ratio width
	localparam int NDIV = 17;         // quotient bits
	localparam int NSTEP = 24;        // rotation steps
	localparam int CW = 32;           // rotation x/y width
	localparam int ZW = 32;           // angle accumulator width
	localparam logic [EW-1:0] EMAX = {EW{1'b1}};
	localparam logic signed [ZW-1:0] HALF_Z = 32'sd117964800;   // 1800 * 65536
	localparam logic signed [ZW-1:0] FULL_Z = 32'sd235929600;   // 3600 * 65536

	typedef struct packed {
		logic [EW-1:0] e0;
		logic [EW-1:0] e1;
		logic [EW-1:0] e2;
		logic [EW-1:0] e3;
	} energy_set_t;

	typedef enum logic [2:0] {
		B_IDLE, B_DIV, B_ROT, B_FIN, B_OUT
	} back_state_t;

	function automatic logic signed [ZW-1:0] arc_of(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 32'sd29491200;
			5'd1: r = 32'sd17409672;
			5'd2: r = 32'sd9198793;
			5'd3: r = 32'sd4669451;
			5'd4: r = 32'sd2343786;
			5'd5: r = 32'sd1173036;
			5'd6: r = 32'sd586661;
			5'd7: r = 32'sd293348;
			5'd8: r = 32'sd146676;
			5'd9: r = 32'sd73339;
			5'd10: r = 32'sd36669;
			5'd11: r = 32'sd18335;
			5'd12: r = 32'sd9167;
			5'd13: r = 32'sd4584;
			5'd14: r = 32'sd2292;
			5'd15: r = 32'sd1146;
			5'd16: r = 32'sd573;
			5'd17: r = 32'sd286;
			5'd18: r = 32'sd143;
			5'd19: r = 32'sd72;
			5'd20: r = 32'sd36;
			5'd21: r = 32'sd18;
			5'd22: r = 32'sd9;
			5'd23: r = 32'sd4;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

// ----- hw/rtl/meba_front.sv -----
// Front part: squares samples, keeps energy sums, pushes finished sets to the queue.
module meba_front (
	input  logic clk,
	input  logic arst_n,
	input  logic signed [15:0] mic0_sample,
	input  logic signed [15:0] mic1_sample,
	input  logic signed [15:0] mic2_sample,
	input  logic signed [15:0] mic3_sample,
	input  logic block_end,
	input  logic in_valid,
	output logic in_ready,
	output logic push,
	output meba_pkg::energy_set_t push_set,
	input  logic q_full
);
	import meba_pkg::*;

	logic [EW-1:0] acc_q [4];
	logic [EW-1:0] nxt [4];
	logic signed [15:0] smp [4];
	logic fire;

	assign smp[0] = mic0_sample;
	assign smp[1] = mic1_sample;
	assign smp[2] = mic2_sample;
	assign smp[3] = mic3_sample;
	assign in_ready = !q_full;
	assign fire = in_valid && in_ready;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [32:0] sq;
			logic [EW:0] s;
			sq = 33'(unsigned'(32'(smp[k] * smp[k])));
			s = {1'b0, acc_q[k]} + (EW+1)'(sq);
			nxt[k] = s[EW] ? EMAX : s[EW-1:0];
		end
	end

	assign push = fire && block_end;
	assign push_set = '{e0: nxt[0], e1: nxt[1], e2: nxt[2], e3: nxt[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) acc_q[k] <= '0;
		end else if (fire) begin
			for (int k = 0; k < 4; k++) acc_q[k] <= block_end ? '0 : nxt[k];
		end
	end
endmodule

// ----- hw/rtl/meba_queue.sv -----
// Short queue of finished energy sets between front and back.
module meba_queue #(
	parameter int DEPTH_LG = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  meba_pkg::energy_set_t push_set,
	output logic full,
	output logic avail,
	input  logic pop,
	output meba_pkg::energy_set_t head
);
	import meba_pkg::*;

	localparam int DEPTH = 1 << DEPTH_LG;
	energy_set_t mem_q [DEPTH];
	logic [DEPTH_LG-1:0] wp_q, rp_q;
	logic [DEPTH_LG:0] cnt_q;

	assign full = cnt_q == (DEPTH_LG+1)'(DEPTH);
	assign avail = cnt_q != '0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (DEPTH_LG+1)'(push) - (DEPTH_LG+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !avail |-> !pop)
		else $error("queue pop while empty");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not advance");
endmodule

// ----- hw/rtl/meba_back.sv -----
// Back part: serial ratio division, CORDIC vectoring and the azimuth output register.
module meba_back (
	input  logic clk,
	input  logic arst_n,
	input  logic avail,
	input  meba_pkg::energy_set_t head,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic [11:0] azimuth_tenths
);
	import meba_pkg::*;

	back_state_t st_q, st_d;
	logic [4:0] cnt_q;
	// two restoring dividers, one quotient bit per cycle
	logic [EW:0] denx_q, deny_q;
	logic [EW:0] remx_q, remy_q;
	logic [NDIV-1:0] qx_q, qy_q;
	logic negx_q, negy_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [11:0] az_q;
	logic [EW+1:0] trx, try_;
	logic signed [QW-1:0] dx, dy;
	logic signed [CW-1:0] xs, ys;
	logic signed [ZW-1:0] t;
	logic [15:0] tt;
	logic [11:0] fin;
	logic last;

	assign last = cnt_q == 5'(NDIV-1);
	assign trx = {remx_q, 1'b0};
	assign try_ = {remy_q, 1'b0};
	assign dx = negx_q ? -QW'(signed'({1'b0, qx_q})) : QW'(signed'({1'b0, qx_q}));
	assign dy = negy_q ? -QW'(signed'({1'b0, qy_q})) : QW'(signed'({1'b0, qy_q}));
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign t = z_q + FULL_Z;
	assign tt = t[ZW-1] ? 16'd0 : t[31:16];
	assign fin = tt >= 16'd3600 ? 12'(tt - 16'd3600) : tt[11:0];

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (avail) st_d = B_DIV;
			B_DIV: if (last) st_d = B_ROT;
			B_ROT: if (cnt_q == 5'(NSTEP-1)) st_d = B_FIN;
			B_FIN: st_d = B_OUT;
			B_OUT: if (out_ready) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = st_q == B_IDLE && avail;
		out_valid = st_q == B_OUT;
	end
	assign azimuth_tenths = az_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= B_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				cnt_q <= '0;
				denx_q <= {1'b0, head.e0} + {1'b0, head.e1} + 1'b1;
				deny_q <= {1'b0, head.e2} + {1'b0, head.e3} + 1'b1;
				negx_q <= head.e1 < head.e0;
				negy_q <= head.e3 < head.e2;
				// numerator is below the denominator, so every quotient bit is fractional
				remx_q <= {1'b0, head.e1 < head.e0 ? head.e0 - head.e1 : head.e1 - head.e0};
				remy_q <= {1'b0, head.e3 < head.e2 ? head.e2 - head.e3 : head.e3 - head.e2};
			end
			B_DIV: begin
				remx_q <= trx >= {1'b0, denx_q} ? (EW+1)'(trx - {1'b0, denx_q})
					: trx[EW:0];
				remy_q <= try_ >= {1'b0, deny_q} ? (EW+1)'(try_ - {1'b0, deny_q})
					: try_[EW:0];
				qx_q <= {qx_q[NDIV-2:0], trx >= {1'b0, denx_q}};
				qy_q <= {qy_q[NDIV-2:0], try_ >= {1'b0, deny_q}};
				cnt_q <= last ? 5'd0 : cnt_q + 1'b1;
			end
			B_ROT: begin
				if (cnt_q == '0) begin
					// setup folded into the first step: take dx, dy fresh
					logic signed [CW-1:0] x0, y0;
					logic signed [ZW-1:0] z0;
					x0 = dx < 0 ? CW'(-dx) <<< 12 : CW'(dx) <<< 12;
					y0 = dx < 0 ? CW'(-dy) <<< 12 : CW'(dy) <<< 12;
					z0 = dx < 0 ? (dy > 0 ? HALF_Z : -HALF_Z) : '0;
					if (y0 >= 0) begin
						x_q <= x0 + y0;
						y_q <= y0 - x0;
						z_q <= z0 + arc_of(5'd0);
					end else begin
						x_q <= x0 - y0;
						y_q <= y0 + x0;
						z_q <= z0 - arc_of(5'd0);
					end
				end else if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + arc_of(cnt_q);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - arc_of(cnt_q);
				end
				cnt_q <= cnt_q + 1'b1;
			end
			B_FIN: begin
				if (dx == 0 && dy == 0) az_q <= 12'd0;
				else if (dy == 0) az_q <= dx < 0 ? 12'd1800 : 12'd0;
				else if (dx == 0) az_q <= dy > 0 ? 12'd900 : 12'd2700;
				else az_q <= fin;
			end
			default: ;
		endcase
	end

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> azimuth_tenths < 12'd3600) else $error("azimuth out of range");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> st_q == B_DIV) else $error("pop did not start division");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(azimuth_tenths))
		else $error("result dropped");
endmodule

// ----- hw/rtl/mic_energy_balance_azimuth_top.sv -----
// Top level of the microphone energy balance azimuth estimator.
// Channel | Ports                                       | Handshake
// in      | mic0..mic3_sample, block_end                | in_valid / in_ready
// out     | azimuth_tenths                              | out_valid / out_ready
// Samples are taken one per cycle while in_ready is high; the energy update is a combinational add.
// A block end result passes through the back part's serial divider, rotation loop and
// finish step; the back part takes the next set only after out_ready accepts the result.
// Two finished sets queue between front and back; input stalls only when it is full.
// Reset (arst_n low) clears the energy sums, queue and back state; no clearing pass.
module mic_energy_balance_azimuth_top #(
	parameter int QUEUE_DEPTH_LG = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic signed [15:0] mic0_sample,
	input  logic signed [15:0] mic1_sample,
	input  logic signed [15:0] mic2_sample,
	input  logic signed [15:0] mic3_sample,
	input  logic block_end,
	input  logic in_valid,
	output logic in_ready,
	output logic [11:0] azimuth_tenths,
	output logic out_valid,
	input  logic out_ready
);
	import meba_pkg::*;

	logic push, q_full, q_avail, pop;
	energy_set_t push_set, head;

	meba_front u_front (
		.clk, .arst_n, .mic0_sample, .mic1_sample, .mic2_sample, .mic3_sample,
		.block_end, .in_valid, .in_ready, .push, .push_set, .q_full
	);

	meba_queue #(.DEPTH_LG(QUEUE_DEPTH_LG)) u_queue (
		.clk, .arst_n, .push, .push_set, .full(q_full), .avail(q_avail),
		.pop, .head
	);

	meba_back u_back (
		.clk, .arst_n, .avail(q_avail), .head, .pop, .out_valid, .out_ready,
		.azimuth_tenths
	);
endmodule
